>>> rtl/core/rwu_pkg.sv
// rmsprop weight update: shared types, constants and arithmetic step functions
// no dependencies; used by the interfaces, the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package rwu_pkg;

    // field widths
    localparam int IDX_W   = 16;
    localparam int DATA_W  = 32;
    localparam int RATE_W  = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGULARIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 3'd3;

    // register reset values
    localparam logic [RATE_W-1:0] RST_LEARNING_RATE = 16'd655;
    localparam logic [RATE_W-1:0] RST_DECAY_RATE    = 16'd58982;
    localparam logic [RATE_W-1:0] RST_REGULARIZE    = 16'd0;
    localparam logic [RATE_W-1:0] RST_EPSILON       = 16'd2;

    // root: 25 result bits from a 50 bit radicand, one bit a stage
    localparam int SQ_STEPS = 25;
    // quotient bits below the overflow limit, one bit a stage
    localparam int DV_STEPS = 34;

    // per item data that rides along the root and divide stages
    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic                    inr;     // index within the cache
        logic                    gneg;
        logic                    gnz;
        logic                    ovf;     // step certainly saturates
        logic signed [DATA_W-1:0] w;
        logic [DATA_W-1:0]       decmag;  // (lambda * |w|) >> 16
        logic [51:0]             nval;    // lr * |g| * 16
    } t_side;

    // one stage of the digit by digit square root
    typedef struct packed {
        logic [27:0] rem;
        logic [24:0] root;
        logic [49:0] x;
    } t_sq;

    // one stage of the restoring divider
    typedef struct packed {
        logic [25:0] rem;
        logic [33:0] quo;
        logic [33:0] num;
        logic [24:0] div;
    } t_dv;

    // forwarding entry for cache values not yet visible in the memory
    typedef struct packed {
        logic                vld;
        logic [IDX_W-1:0]    idx;
        logic [DATA_W-1:0]   cache;
    } t_fw;

    function automatic t_sq sqrt_step(input t_sq a);
        logic [27:0] rs;
        logic [27:0] tr;
        t_sq o;
        rs = {a.rem[25:0], a.x[49:48]};
        tr = {1'b0, a.root, 2'b01};
        o.x = {a.x[47:0], 2'b00};
        if (rs >= tr) begin
            o.rem  = rs - tr;
            o.root = {a.root[23:0], 1'b1};
        end else begin
            o.rem  = rs;
            o.root = {a.root[23:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_dv div_step(input t_dv a);
        logic [25:0] rs;
        logic [25:0] dv;
        t_dv o;
        rs = {a.rem[24:0], a.num[33]};
        dv = {1'b0, a.div};
        o.num = {a.num[32:0], 1'b0};
        o.div = a.div;
        if (rs >= dv) begin
            o.rem = rs - dv;
            o.quo = {a.quo[32:0], 1'b1};
        end else begin
            o.rem = rs;
            o.quo = {a.quo[32:0], 1'b0};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rwu_req_if.sv
// request channel of the rmsprop weight update: valid, ready and one item
// depends on rwu_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface rwu_req_if;
    import rwu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         param_index;
    logic signed [DATA_W-1:0] gradient;
    logic signed [DATA_W-1:0] weight_in;

    modport source (output valid, param_index, gradient, weight_in, input ready);
    modport sink   (input valid, param_index, gradient, weight_in, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rwu_res_if.sv
// result channel of the rmsprop weight update: valid, ready and one result
// depends on rwu_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface rwu_res_if;
    import rwu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         result_index;
    logic signed [DATA_W-1:0] weight_out;

    modport source (output valid, result_index, weight_out, input ready);
    modport sink   (input valid, result_index, weight_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rmsprop_weight_update_top.sv
// rmsprop weight update: cache memory, update pipeline, root and divide stages
// depends on rwu_pkg, rwu_req_if, rwu_res_if and rwu_ram
//
// One request per cycle is accepted and one result leaves per cycle, once the
// cache sweep is done and while results are taken; a result passes through 4
// cache stages (the first loaded at the accepting edge), 25 root stages, one
// divide setup stage, 34 divide stages and the output register. The whole
// pipeline holds while a result waits to be taken. The squared-gradient cache
// sits in one memory of NUM_PARAMS words, read as a request is accepted and
// written from stage d; newer values still in flight are forwarded.
// After reset the cache is swept to zero, one word a cycle, so requests are
// first taken once all NUM_PARAMS words are cleared; configuration writes are
// taken at any time. A request whose index is not below NUM_PARAMS leaves the
// cache alone and returns its weight unchanged.
`timescale 1ns / 1ps
`default_nettype none

module rmsprop_weight_update_top #(
    parameter int NUM_PARAMS = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rwu_req_if.sink                            i_req,
    rwu_res_if.source                          o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [rwu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rwu_pkg::RATE_W-1:0]    i_cfg_data
);
    import rwu_pkg::*;

    localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

    // configuration registers
    logic [RATE_W-1:0] r_lr, r_dr, r_lam, r_eps;

    // control
    logic          advance;
    logic          acc_in;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // stage a: request registered, cache word in flight
    logic                     r_a_vld, r_a_inr;
    logic [IDX_W-1:0]         r_a_idx;
    logic [DATA_W-1:0]        r_a_g, r_a_w;
    logic [DATA_W-1:0]        a_gmag, a_wmag;
    logic [DATA_W-1:0]        ram_q;

    // stage b: products
    logic                     r_b_vld, r_b_inr, r_b_gneg, r_b_gnz;
    logic [IDX_W-1:0]         r_b_idx;
    logic [DATA_W-1:0]        r_b_w, r_b_cache;
    logic [63:0]              r_b_sq64;
    logic [47:0]              r_b_lrg, r_b_decp;
    logic [DATA_W-1:0]        b_sq;

    // stage c: new-gradient term of the blend
    logic                     r_c_vld;
    t_side                    r_c_side;
    logic [DATA_W-1:0]        r_c_cache;
    logic [48:0]              r_c_t;
    logic [DATA_W-1:0]        c_cache;
    logic [48:0]              c_acc;

    // stage d: new cache word
    logic                     r_d_vld;
    t_side                    r_d_side;
    logic [DATA_W-1:0]        r_d_cache;
    logic [32:0]              d_s;
    t_sq                      sq_init;
    t_fw                      r_fw [3];

    // root stages
    logic [SQ_STEPS-1:0]      r_sq_vld;
    t_sq                      r_sq [SQ_STEPS];
    t_side                    r_sq_side [SQ_STEPS];

    // divide setup and divide stages
    logic                     r_p_vld;
    t_dv                      r_p;
    t_side                    r_p_side;
    t_side                    p_side;
    logic [24:0]              p_root;
    logic [DV_STEPS-1:0]      r_dv_vld;
    t_dv                      r_dv [DV_STEPS];
    t_side                    r_dv_side [DV_STEPS];

    // result assembly
    t_side                    f_side;
    logic [34:0]              f_smag;
    logic signed [37:0]       f_ws, f_st, f_dc, f_res;
    logic [DATA_W-1:0]        f_wout;
    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_idx;
    logic [DATA_W-1:0]        r_out_w;

    // ram ports
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;

    // handshake
    assign advance     = !r_out_valid || o_res.ready;
    assign i_req.ready = advance && !r_clr_busy;
    assign acc_in      = i_req.valid && i_req.ready;

    assign o_res.valid        = r_out_valid;
    assign o_res.result_index = r_out_idx;
    assign o_res.weight_out   = r_out_w;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= RST_LEARNING_RATE;
            r_dr  <= RST_DECAY_RATE;
            r_lam <= RST_REGULARIZE;
            r_eps <= RST_EPSILON;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEARNING_RATE: r_lr  <= i_cfg_data;
                CFG_DECAY_RATE:    r_dr  <= i_cfg_data;
                CFG_REGULARIZE:    r_lam <= i_cfg_data;
                CFG_EPSILON:       r_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(NUM_PARAMS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // cache memory: sweep writes zeros, pipeline writes from stage d
    assign ram_we    = r_clr_busy || (advance && r_d_vld && r_d_side.inr);
    assign ram_waddr = r_clr_busy ? r_clr_addr : AW'(r_d_side.idx);
    assign ram_wdata = r_clr_busy ? '0 : r_d_cache;

    rwu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_PARAMS)
    ) u_cache (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (advance),
        .i_raddr (AW'(i_req.param_index)),
        .o_rdata (ram_q)
    );

    // valid bits of all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            r_d_vld     <= 1'b0;
            r_sq_vld    <= '0;
            r_p_vld     <= 1'b0;
            r_dv_vld    <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_a_vld     <= acc_in;
            r_b_vld     <= r_a_vld;
            r_c_vld     <= r_b_vld;
            r_d_vld     <= r_c_vld;
            r_sq_vld    <= {r_sq_vld[SQ_STEPS-2:0], r_d_vld};
            r_p_vld     <= r_sq_vld[SQ_STEPS-1];
            r_dv_vld    <= {r_dv_vld[DV_STEPS-2:0], r_p_vld};
            r_out_valid <= r_dv_vld[DV_STEPS-1];
        end
    end

    // forwarding line behind stage d
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_fw[k].vld <= 1'b0;
            end
        end else if (advance) begin
            r_fw[0].vld   <= r_d_vld && r_d_side.inr;
            r_fw[0].idx   <= r_d_side.idx;
            r_fw[0].cache <= r_d_cache;
            for (int k = 1; k < 3; k++) begin
                r_fw[k] <= r_fw[k-1];
            end
        end
    end

    // stage a, b combinational parts
    assign a_gmag = r_a_g[DATA_W-1] ? (~r_a_g + 1'b1) : r_a_g;
    assign a_wmag = r_a_w[DATA_W-1] ? (~r_a_w + 1'b1) : r_a_w;
    assign b_sq   = (r_b_sq64[63:56] != '0) ? '1 : r_b_sq64[55:24];

    // cache forwarding: the youngest in-flight write to the same entry wins
    always_comb begin
        c_cache = r_c_cache;
        if (r_fw[2].vld && r_fw[2].idx == r_c_side.idx) c_cache = r_fw[2].cache;
        if (r_fw[1].vld && r_fw[1].idx == r_c_side.idx) c_cache = r_fw[1].cache;
        if (r_fw[0].vld && r_fw[0].idx == r_c_side.idx) c_cache = r_fw[0].cache;
        if (r_d_vld && r_d_side.inr && r_d_side.idx == r_c_side.idx) c_cache = r_d_cache;
    end

    // blend of old cache and new squared gradient
    assign c_acc = 49'(r_dr) * 49'(c_cache) + r_c_t + 49'd32768;

    // root radicand (cache + eps) << 16
    assign d_s          = 33'(r_d_cache) + 33'(r_eps);
    assign sq_init.rem  = '0;
    assign sq_init.root = '0;
    assign sq_init.x    = {1'b0, d_s, 16'd0};

    // divide setup: overflow test and divisor
    assign p_root = r_sq[SQ_STEPS-1].root;
    always_comb begin
        p_side = r_sq_side[SQ_STEPS-1];
        if (p_root == '0) begin
            p_side.ovf = p_side.gnz;
        end else begin
            p_side.ovf = (25'(p_side.nval[51:34]) >= p_root);
        end
    end

    // data path registers, held while the output waits
    always_ff @(posedge i_clk) begin
        if (advance) begin
            // stage a
            r_a_idx <= i_req.param_index;
            r_a_g   <= i_req.gradient;
            r_a_w   <= i_req.weight_in;
            r_a_inr <= (32'(i_req.param_index) < 32'(NUM_PARAMS));

            // stage b
            r_b_idx   <= r_a_idx;
            r_b_inr   <= r_a_inr;
            r_b_gneg  <= r_a_g[DATA_W-1];
            r_b_gnz   <= (r_a_g != '0);
            r_b_w     <= r_a_w;
            r_b_cache <= ram_q;
            r_b_sq64  <= 64'(a_gmag) * 64'(a_gmag);
            r_b_lrg   <= 48'(r_lr) * 48'(a_gmag);
            r_b_decp  <= 48'(r_lam) * 48'(a_wmag);

            // stage c
            r_c_side.idx    <= r_b_idx;
            r_c_side.inr    <= r_b_inr;
            r_c_side.gneg   <= r_b_gneg;
            r_c_side.gnz    <= r_b_gnz;
            r_c_side.ovf    <= 1'b0;
            r_c_side.w      <= r_b_w;
            r_c_side.decmag <= r_b_decp[47:16];
            r_c_side.nval   <= {r_b_lrg, 4'd0};
            r_c_cache       <= r_b_cache;
            r_c_t           <= (49'd65536 - 49'(r_dr)) * 49'(b_sq);

            // stage d
            r_d_side  <= r_c_side;
            r_d_cache <= c_acc[47:16];

            // root stages
            r_sq[0]      <= sqrt_step(sq_init);
            r_sq_side[0] <= r_d_side;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_sq[k]      <= sqrt_step(r_sq[k-1]);
                r_sq_side[k] <= r_sq_side[k-1];
            end

            // divide setup
            r_p_side <= p_side;
            r_p.rem  <= 26'(p_side.nval[51:34]);
            r_p.quo  <= '0;
            r_p.num  <= p_side.nval[33:0];
            r_p.div  <= (p_root == '0) ? 25'd1 : p_root;

            // divide stages
            r_dv[0]      <= div_step(r_p);
            r_dv_side[0] <= r_p_side;
            for (int k = 1; k < DV_STEPS; k++) begin
                r_dv[k]      <= div_step(r_dv[k-1]);
                r_dv_side[k] <= r_dv_side[k-1];
            end

            // output register
            r_out_idx <= f_side.idx;
            r_out_w   <= f_wout;
        end
    end

    // result: w - step - decay, saturated; w unchanged for an out-of-range index
    always_comb begin
        f_side = r_dv_side[DV_STEPS-1];
        f_smag = f_side.ovf ? 35'h4_0000_0000 : {1'b0, r_dv[DV_STEPS-1].quo};
        f_ws   = {{6{f_side.w[DATA_W-1]}}, f_side.w};
        f_st   = f_side.gneg ? -$signed({3'b000, f_smag}) : $signed({3'b000, f_smag});
        f_dc   = f_side.w[DATA_W-1] ? -$signed({6'd0, f_side.decmag})
                                    : $signed({6'd0, f_side.decmag});
        f_res  = f_ws - f_st - f_dc;
        if (!f_side.inr) begin
            f_wout = f_side.w;
        end else if (f_res > 38'sh0_7FFF_FFFF) begin
            f_wout = 32'h7FFF_FFFF;
        end else if (f_res < -38'sh0_8000_0000) begin
            f_wout = 32'h8000_0000;
        end else begin
            f_wout = f_res[31:0];
        end
    end

    // no request is taken while the cache is being swept
    a_clr_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_req.ready)
        else $error("request accepted during cache sweep");

    // the sweep never competes with a pipeline write
    a_clr_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_d_vld)
        else $error("pipeline write during cache sweep");

    // a waiting result is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out_w)))
        else $error("waiting result lost");

    // pipeline cache writes only ever go to in-range entries
    a_wr_inr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !r_clr_busy) |-> (r_d_vld && r_d_side.inr))
        else $error("cache write from an out-of-range request");
endmodule

`default_nettype wire

>>> rtl/core/rwu_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rwu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old contents when both ports hit one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

>>> tb/sv/tb_rmsprop_weight_update_top.sv
// testbench of rmsprop_weight_update_top: directed and random requests, checked against
// a local fixed point predictor of the cache, root, divide and weight decay
// depends on rwu_pkg, rwu_req_if, rwu_res_if and the top level
`timescale 1ns / 1ps

module tb_rmsprop_weight_update_top;
    import rwu_pkg::*;

    localparam int NPARAM      = 65536;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 600000;
    // an index past the four registers, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd6;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] weight;
    } t_weight_exp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [RATE_W-1:0] i_cfg_data = '0;

    rwu_req_if req_ch();
    rwu_res_if res_ch();

    rmsprop_weight_update_top #(.NUM_PARAMS(NPARAM)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] sq_cache [NPARAM];
    logic [15:0] lr_q, decay_q, lambda_q, eps_q;
    t_weight_exp pending_weights[$];
    int errors = 0;
    int n_updates = 0;
    int n_weights = 0;
    int cycles = 0;
    bit stall_on = 1'b0;

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned rt, b;
        rt = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= rt + b) begin
                x -= rt + b;
                rt = (rt >> 1) + b;
            end else begin
                rt >>= 1;
            end
            b >>= 2;
        end
        return rt;
    endfunction

    // blend the squared gradient into the cache and return the new weight
    function automatic logic signed [31:0] rmsprop_weight(logic [15:0] idx,
                                                          logic signed [31:0] g,
                                                          logic signed [31:0] w);
        longint unsigned gmag, wmag, sq, acc, cnew, s, r, stepmag, decmag;
        longint res;
        gmag = g < 0 ? longint'(-longint'(g)) : longint'(g);
        wmag = w < 0 ? longint'(-longint'(w)) : longint'(w);
        sq = (gmag * gmag) >> 24;
        if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
        acc = longint'(decay_q) * sq_cache[idx] + (64'd65536 - decay_q) * sq + 64'd32768;
        cnew = acc >> 16;
        if (cnew > 64'hFFFF_FFFF) cnew = 64'hFFFF_FFFF;
        sq_cache[idx] = cnew[31:0];
        s = cnew + eps_q;
        r = int_root(s << 16);
        if (r == 0) stepmag = (gmag == 0) ? 0 : (64'd1 << 50);
        else stepmag = (longint'(lr_q) * gmag * 16) / r;
        decmag = (longint'(lambda_q) * wmag) >> 16;
        res = longint'(w);
        res -= (g < 0) ? -longint'(stepmag) : longint'(stepmag);
        res -= (w < 0) ? -longint'(decmag) : longint'(decmag);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one request, predict at acceptance, then idle a random while
    task automatic send_update(logic [15:0] idx, logic [31:0] g, logic [31:0] w);
        t_weight_exp e;
        int gap;
        @(negedge i_clk);
        req_ch.valid       <= 1'b1;
        req_ch.param_index <= idx;
        req_ch.gradient    <= g;
        req_ch.weight_in   <= w;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        e.idx = idx;
        e.weight = rmsprop_weight(idx, g, w);
        pending_weights.push_back(e);
        n_updates++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic idle_request();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    // wait for every expected weight, then let the pipeline settle
    task automatic drain();
        idle_request();
        while (pending_weights.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LEARNING_RATE: lr_q     = val;
            CFG_DECAY_RATE:    decay_q  = val;
            CFG_REGULARIZE:    lambda_q = val;
            CFG_EPSILON:       eps_q    = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_rates(logic [15:0] lr, logic [15:0] d, logic [15:0] lam,
                             logic [15:0] eps);
        drain();
        write_reg(CFG_LEARNING_RATE, lr);
        write_reg(CFG_DECAY_RATE, d);
        write_reg(CFG_REGULARIZE, lam);
        write_reg(CFG_EPSILON, eps);
    endtask

    // extremes of the fields under the reset rates
    task automatic test_field_extremes();
        send_update(16'd0, 32'sd0, 32'sd0);
        send_update(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_update(16'hFFFF, 32'h8000_0000, 32'h8000_0000);
        send_update(16'd1, 32'h0100_0000, 32'h8000_0000);
        send_update(16'd1, 32'hFF00_0000, 32'h7FFF_FFFF);
        send_update(16'd1, 32'sd1, 32'sd1);
        send_update(16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_update(16'h8000, 32'h0000_0100, 32'h0123_4567);
    endtask

    // zero root: empty cache, zero epsilon, gradient too small to register; then a write to an unused register index
    task automatic test_zero_root();
        set_rates(16'd655, 16'd58982, 16'd0, 16'd0);
        send_update(16'd100, 32'sd1, 32'sd0);
        send_update(16'd101, -32'sd1, 32'sd0);
        send_update(16'd102, 32'sd0, 32'sd5000);
        send_update(16'd103, 32'sd2, 32'h7FFF_0000);
        drain();
        write_reg(CFG_NONE, 16'h1234);
    endtask

    // rate extremes: full step, no decay, full decay, full weight decay
    task automatic test_rate_extremes();
        set_rates(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        send_update(16'd7, 32'h0100_0000, 32'h7FFF_FFFF);
        send_update(16'd7, 32'hFF00_0000, 32'h8000_0000);
        send_update(16'd8, 32'h7FFF_FFFF, 32'sd0);
        set_rates(16'd1, 16'hFFFF, 16'd0, 16'd1);
        send_update(16'd7, 32'h0400_0000, 32'h0100_0000);
        send_update(16'd7, 32'sd0, 32'hF000_0000);
        send_update(16'd9, 32'h8000_0000, 32'sd12345);
    endtask

    function automatic logic [31:0] rand_grad();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            default: return $urandom_range(0, 255) - 128;
        endcase
    endfunction

    // random updates, mostly on a few hot indexes so the cache feeds back
    task automatic test_random_updates(int count);
        logic [15:0] idx;
        logic [31:0] w;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) != 0) idx = $urandom_range(0, 7);
            else idx = $urandom;
            w = ($urandom_range(0, 1) != 0) ? $urandom
                                           : $signed($urandom_range(0, 32'h07FF_FFFF))
                                             - 32'sh0400_0000;
            send_update(idx, rand_grad(), w);
        end
    endtask

    // receiver stalls, switched between stalling and free-running stretches
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) < 2) stall_on <= ~stall_on;
        res_ch.ready <= !stall_on || (pick_gap() == 0);
    end

    // compare each weight with the oldest prediction
    always @(posedge i_clk) begin
        t_weight_exp e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_weights++;
            if (pending_weights.size() == 0) begin
                $error("unexpected weight: index %0d weight %0d",
                       res_ch.result_index, res_ch.weight_out);
                errors++;
            end else begin
                e = pending_weights.pop_front();
                if (res_ch.result_index !== e.idx) begin
                    $error("result_index: expected %0d actual %0d", e.idx,
                           res_ch.result_index);
                    errors++;
                end
                if (res_ch.weight_out !== e.weight) begin
                    $error("weight_out: expected %0d actual %0d", e.weight,
                           res_ch.weight_out);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.param_index = '0;
        req_ch.gradient    = '0;
        req_ch.weight_in   = '0;
        res_ch.ready       = 1'b0;
        foreach (sq_cache[i]) sq_cache[i] = '0;
        lr_q     = RST_LEARNING_RATE;
        decay_q  = RST_DECAY_RATE;
        lambda_q = RST_REGULARIZE;
        eps_q    = RST_EPSILON;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_zero_root();
        test_rate_extremes();
        set_rates(16'd655, 16'd58982, 16'd0, 16'd2);
        test_random_updates(150);
        // hold off until every weight is back, then resume
        drain();
        test_random_updates(100);
        set_rates(16'd20000, 16'd32768, 16'd300, 16'd0);
        test_random_updates(150);
        set_rates(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random_updates(75);
        set_rates(16'd0, 16'd0, 16'd0, 16'd1);
        test_random_updates(75);
        drain();

        $display("covered %0d updates, %0d weights checked, over 7 rate settings",
                 n_updates, n_weights);
        $display("including zero root, saturation and ignored register writes");
        if (errors == 0 && pending_weights.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
